@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked each clock, suppressed during reset
`define CHK_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

@@ hw/rtl/pta_pkg.sv @@
// Shared types and constants for the partition table allocator.
// No dependencies.
package pta_pkg;
   localparam int SLOTS = 4;
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_DEL = 2'd1;
   localparam logic [1:0] ACT_RSZ = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] CSR_DISK = 2'd0;
   localparam logic [1:0] CSR_HDR = 2'd1;
   localparam logic [1:0] CSR_FIT = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_NOSLOT = 3'd2;
   localparam logic [2:0] ST_NOSPACE = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_SHRINK = 3'd5;
   localparam logic [2:0] ST_GROW = 3'd6;
   localparam logic [2:0] ST_INVALID = 3'd7;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, lookups
      logic scan_init;  // reset gap scan position
      logic scan_step;  // take one gap
      logic rsz_eval;   // resize bound check
      logic commit;     // update table, form result
      logic [2:0] fail; // status for failure result
      logic fail_en;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic invalid;
      logic [1:0] action;
      logic found;
      logic has_free;
      logic ext_block;
      logic scan_last;  // current gap is the tail gap
      logic have;       // a fitting gap was found
      logic shrink_bad;
      logic grow_bad;
   } stat_type;
endpackage

@@ hw/rtl/pta_ctrl.sv @@
// Command sequencer for the partition table allocator.
// Depends on pta_pkg.
module pta_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  pta_pkg::stat_type stat,
   output pta_pkg::cmd_type cmd
);
   import pta_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_RSZ = 3'd4;
   localparam logic [2:0] S_RCHK = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_IDLE;
            if (stat.invalid) begin
               cmd.fail_en = 1'b1;
               cmd.fail = ST_INVALID;
            end else if (stat.action == ACT_ADD) begin
               if (stat.found) begin
                  cmd.fail_en = 1'b1;
                  cmd.fail = ST_DUP;
               end else if (!stat.has_free || stat.ext_block) begin
                  cmd.fail_en = 1'b1;
                  cmd.fail = ST_NOSLOT;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (!stat.found) begin
               cmd.fail_en = 1'b1;
               cmd.fail = ST_NOTFOUND;
            end else if (stat.action == ACT_DEL) begin
               cmd.commit = 1'b1;
            end else begin
               state_in = S_RSZ;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = S_PLACE;
         end
         S_PLACE: begin
            state_in = S_IDLE;
            if (stat.have) begin
               cmd.commit = 1'b1;
            end else begin
               cmd.fail_en = 1'b1;
               cmd.fail = ST_NOSPACE;
            end
         end
         S_RSZ: begin
            cmd.rsz_eval = 1'b1;
            state_in = S_RCHK;
         end
         S_RCHK: begin
            state_in = S_IDLE;
            if (stat.shrink_bad) begin
               cmd.fail_en = 1'b1;
               cmd.fail = ST_SHRINK;
            end else if (stat.grow_bad) begin
               cmd.fail_en = 1'b1;
               cmd.fail = ST_GROW;
            end else begin
               cmd.commit = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ hw/rtl/pta_dp.sv @@
// Datapath of the partition table allocator: table, gap scan, resize check.
// Depends on pta_pkg.
module pta_dp (
   input  logic clock,
   input  logic reset,
   input  pta_pkg::cmd_type cmd,
   output pta_pkg::stat_type stat,
   input  logic [30:0] disk_size,
   input  logic [11:0] header_size,
   input  logic [1:0] fit_mode,
   input  logic [1:0] req_action,
   input  logic [31:0] req_name_key,
   input  logic signed [31:0] req_amount,
   input  logic [1:0] req_unit,
   input  logic req_part_type,
   input  logic [1:0] req_part_fit,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [1:0] rsp_slot,
   output logic [30:0] rsp_part_start,
   output logic [30:0] rsp_part_size
);
   import pta_pkg::*;

   logic [SLOTS-1:0] used_ff, ext_ff;
   logic [30:0] start_ff [SLOTS];
   logic [30:0] size_ff [SLOTS];
   logic [31:0] name_ff [SLOTS];
   logic [1:0] fit_ff [SLOTS];

   logic [1:0] action_ff;
   logic [31:0] key_ff;
   logic ptype_ff;
   logic [1:0] pfit_ff;
   logic [30:0] mag_ff;
   logic neg_ff, invalid_ff;
   logic found_ff, hasfree_ff, extb_ff;
   logic [SW-1:0] hit_ff, free_ff;

   logic [SLOTS-1:0] visited_ff;
   logic [31:0] pos_ff;
   logic have_ff;
   logic [30:0] found_pos_ff;
   logic [31:0] metric_ff;
   logic [31:0] end_ff;
   logic shrink_bad_ff, grow_bad_ff;

   logic rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [1:0] rsp_slot_ff;
   logic [30:0] rsp_start_ff, rsp_size_ff;

   // scale and range check of the requested amount
   logic [31:0] mag32;
   logic [51:0] scaled_w;
   logic neg, inval;
   always_comb begin
      neg = req_amount[31];
      mag32 = neg ? (~req_amount + 32'd1) : req_amount;
      case (req_unit)
         2'd0: scaled_w = {20'd0, mag32};
         2'd1: scaled_w = {10'd0, mag32, 10'd0};
         default: scaled_w = {mag32, 20'd0};
      endcase
      inval = (req_action == 2'd3) || (req_unit == 2'd3) || (scaled_w > 52'(MAX31))
              || ((req_action == ACT_ADD) && neg && (mag32 != 32'd0));
   end

   // name lookup and free entry
   logic fnd, hasf, extb;
   logic [SW-1:0] hit, fre;
   always_comb begin
      fnd = 1'b0;
      hasf = 1'b0;
      extb = 1'b0;
      hit = '0;
      fre = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && name_ff[i] == req_name_key) begin
            fnd = 1'b1;
            hit = SW'(i);
         end
         if (!used_ff[i]) begin
            hasf = 1'b1;
            fre = SW'(i);
         end
         if (used_ff[i] && ext_ff[i] && req_part_type) extb = 1'b1;
      end
   end

   // nearest unvisited entry at or after the scan position
   logic nx_ok;
   logic [SW-1:0] nx;
   logic [31:0] nx_d;
   always_comb begin
      nx_ok = 1'b0;
      nx = '0;
      nx_d = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (used_ff[i] && !visited_ff[i] && {1'b0, start_ff[i]} >= pos_ff) begin
            if (!nx_ok || ({1'b0, start_ff[i]} - pos_ff) < nx_d) begin
               nx_ok = 1'b1;
               nx = SW'(i);
               nx_d = {1'b0, start_ff[i]} - pos_ff;
            end
         end
      end
   end

   logic [31:0] gap_len;
   logic gap_fit, gap_take;
   always_comb begin
      gap_len = nx_ok ? nx_d : (end_ff - pos_ff);
      gap_fit = (end_ff >= pos_ff || nx_ok) && (gap_len > {1'b0, mag_ff});
      if (fit_mode == FIT_FIRST) gap_take = gap_fit && !have_ff;
      else if (fit_mode == FIT_WORST) gap_take = gap_fit && (!have_ff || gap_len > metric_ff);
      else gap_take = gap_fit &&
                      (!have_ff || (gap_len - {1'b0, mag_ff}) < metric_ff);
   end

   // resize bound: nearest other entry at or after the current end
   logic [31:0] cend;
   logic b_ok;
   logic [30:0] b_start;
   always_comb begin
      cend = {1'b0, start_ff[hit_ff]} + {1'b0, size_ff[hit_ff]};
      b_ok = 1'b0;
      b_start = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (used_ff[i] && SW'(i) != hit_ff && {1'b0, start_ff[i]} >= cend) begin
            if (!b_ok || start_ff[i] < b_start) begin
               b_ok = 1'b1;
               b_start = start_ff[i];
            end
         end
      end
   end

   // room goes negative (top bit set) when the entry ends past the disk end
   logic [32:0] room;
   logic [31:0] new_size;
   always_comb begin
      room = b_ok ? ({2'b0, b_start} - {1'b0, cend}) : ({1'b0, end_ff} - {1'b0, cend});
      new_size = neg_ff ? ({1'b0, size_ff[hit_ff]} - {1'b0, mag_ff})
                        : ({1'b0, size_ff[hit_ff]} + {1'b0, mag_ff});
   end

   logic [31:0] dend;
   assign dend = {20'd0, header_size} + {1'b0, disk_size};

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         ext_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit || cmd.fail_en;
         if (cmd.commit && action_ff == ACT_ADD) begin
            used_ff[free_ff] <= 1'b1;
            ext_ff[free_ff] <= ptype_ff;
         end else if (cmd.commit && action_ff == ACT_DEL) begin
            used_ff[hit_ff] <= 1'b0;
            ext_ff[hit_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         key_ff <= req_name_key;
         ptype_ff <= req_part_type;
         pfit_ff <= req_part_fit;
         mag_ff <= scaled_w[30:0];
         neg_ff <= neg;
         invalid_ff <= inval;
         found_ff <= fnd;
         hasfree_ff <= hasf;
         extb_ff <= extb;
         hit_ff <= hit;
         free_ff <= fre;
         end_ff <= (dend > {1'b0, MAX31}) ? {1'b0, MAX31} : dend;
      end
      if (cmd.scan_init) begin
         pos_ff <= {20'd0, header_size};
         visited_ff <= '0;
         have_ff <= 1'b0;
         metric_ff <= '0;
         found_pos_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (gap_take) begin
            have_ff <= 1'b1;
            found_pos_ff <= pos_ff[30:0];
            metric_ff <= (fit_mode == FIT_WORST) ? gap_len : (gap_len - {1'b0, mag_ff});
         end
         if (nx_ok) begin
            visited_ff[nx] <= 1'b1;
            pos_ff <= {1'b0, start_ff[nx]} + {1'b0, size_ff[nx]};
         end
      end
      if (cmd.rsz_eval) begin
         shrink_bad_ff <= neg_ff && (mag_ff > size_ff[hit_ff]);
         grow_bad_ff <= !neg_ff && (room[32] || (room < {2'b0, mag_ff}));
      end
      if (cmd.commit) begin
         rsp_status_ff <= ST_OK;
         case (action_ff)
            ACT_ADD: begin
               start_ff[free_ff] <= found_pos_ff;
               size_ff[free_ff] <= mag_ff;
               name_ff[free_ff] <= key_ff;
               fit_ff[free_ff] <= pfit_ff;
               rsp_slot_ff <= 2'(free_ff);
               rsp_start_ff <= found_pos_ff;
               rsp_size_ff <= mag_ff;
            end
            ACT_DEL: begin
               size_ff[hit_ff] <= '0;
               rsp_slot_ff <= 2'(hit_ff);
               rsp_start_ff <= start_ff[hit_ff];
               rsp_size_ff <= '0;
            end
            default: begin
               size_ff[hit_ff] <= new_size[30:0];
               rsp_slot_ff <= 2'(hit_ff);
               rsp_start_ff <= start_ff[hit_ff];
               rsp_size_ff <= new_size[30:0];
            end
         endcase
      end else if (cmd.fail_en) begin
         rsp_status_ff <= cmd.fail;
         rsp_slot_ff <= '0;
         rsp_start_ff <= '0;
         rsp_size_ff <= '0;
      end
   end

   // fit tag is stored but never read back and does not affect allocation
   logic fit_unused;
   assign fit_unused = ^fit_ff[0];

   assign stat.invalid = invalid_ff;
   assign stat.action = action_ff;
   assign stat.found = found_ff;
   assign stat.has_free = hasfree_ff;
   assign stat.ext_block = extb_ff;
   assign stat.scan_last = !nx_ok || fit_unused & 1'b0;
   assign stat.have = have_ff;
   assign stat.shrink_bad = shrink_bad_ff;
   assign stat.grow_bad = grow_bad_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_part_start = rsp_start_ff;
   assign rsp_part_size = rsp_size_ff;
endmodule

@@ hw/rtl/partition_table_allocator_core.sv @@
// Channel     Handshake               Payload
// req         start / busy            action name_key amount unit part_type part_fit
// rsp         rsp_valid (one cycle)   status slot part_start part_size
// csr         csr_valid / csr_ready   csr_index csr_data
// Invalid, delete and early add failures are answered straight from decode;
// resize passes through bound evaluation and check states; add scans one gap per
// slot visited plus the tail gap, then places the entry.
// Reset is synchronous; the table is empty after it. Results cannot be stalled.
// Top level of the partition table allocator. Depends on pta_pkg, pta_ctrl,
// pta_dp and assert_macros.svh.
`include "assert_macros.svh"
module partition_table_allocator_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_action,
   input  logic [31:0] req_name_key,
   input  logic signed [31:0] req_amount,
   input  logic [1:0] req_unit,
   input  logic req_part_type,
   input  logic [1:0] req_part_fit,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [1:0] rsp_slot,
   output logic [30:0] rsp_part_start,
   output logic [30:0] rsp_part_size,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   import pta_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [30:0] disk_ff;
   logic [11:0] hdr_ff;
   logic [1:0] fit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff <= '0;
         hdr_ff <= 12'd156;
         fit_ff <= FIT_FIRST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DISK: disk_ff <= csr_data[30:0];
            CSR_HDR: hdr_ff <= csr_data[11:0];
            CSR_FIT: fit_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   pta_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   pta_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .disk_size(disk_ff), .header_size(hdr_ff), .fit_mode(fit_ff),
      .req_action(req_action), .req_name_key(req_name_key), .req_amount(req_amount),
      .req_unit(req_unit), .req_part_type(req_part_type), .req_part_fit(req_part_fit),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_part_start(rsp_part_start), .rsp_part_size(rsp_part_size)
   );

   `CHK_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted request not busy")
   `CHK_IMPL(a_rsp_busy, clock, reset, rsp_valid, !busy, "result while still busy")
   `CHK_IMPL(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      rsp_part_size == 31'd0 && rsp_slot == 2'd0, "failure result not cleared")
endmodule

@@ tb/sv/tb_partition_table_allocator_core.sv @@
// Self-checking testbench for partition_table_allocator_core: directed and random
// add/delete/resize commands checked against an in-bench partition table model.
// Depends on pta_pkg and the allocator RTL.
`timescale 1ns / 100ps
module tb_partition_table_allocator_core;
   import pta_pkg::*;

   typedef struct {
      logic [1:0] action;
      logic [31:0] key;
      logic [31:0] amount;
      logic [1:0] unit;
      logic ptype;
      logic [1:0] pfit;
   } cmd_t;

   typedef struct {
      logic [2:0] status;
      logic [1:0] slot;
      logic [30:0] pstart;
      logic [30:0] psize;
   } outcome_t;

   logic clock, reset, start, busy;
   logic [1:0] req_action, req_unit, req_part_fit;
   logic [31:0] req_name_key;
   logic signed [31:0] req_amount;
   logic req_part_type;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [1:0] rsp_slot;
   logic [30:0] rsp_part_start, rsp_part_size;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   partition_table_allocator_core uut (.*);

   // table copy kept by the bench
   bit tbl_used[SLOTS], tbl_ext[SLOTS];
   longint tbl_start[SLOTS], tbl_size[SLOTS];
   logic [31:0] tbl_name[SLOTS];
   longint cfg_disk = 0, cfg_hdr = 156;
   int cfg_fit = 0;

   cmd_t pending_cmds[$];
   outcome_t expected_outcomes[$];
   cmd_t cur_cmd;
   int idle_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic longint disk_limit();
      longint e = cfg_hdr + cfg_disk;
      return (e > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : e;
   endfunction

   function automatic int nearest_from(longint pos, bit [SLOTS-1:0] seen, int skip);
      int best = -1;
      longint bd = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_used[i] || i == skip || seen[i] || tbl_start[i] < pos) continue;
         if (best < 0 || tbl_start[i] - pos < bd) begin
            best = i;
            bd = tbl_start[i] - pos;
         end
      end
      return best;
   endfunction

   function automatic int lookup_name(logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_used[i] && tbl_name[i] == key) return i;
      return -1;
   endfunction

   function automatic outcome_t apply_command(cmd_t c);
      outcome_t o;
      longint amt, scaled, x, gl, metric, found, sz, cend, space;
      bit valid, have, ext;
      bit [SLOTS-1:0] seen;
      int freei, i, j;
      o = '{ST_INVALID, 0, 0, 0};
      amt = longint'(signed'(c.amount));
      valid = (c.action <= ACT_RSZ) && (c.unit != 2'd3);
      scaled = 0;
      if (valid) begin
         scaled = amt * ((c.unit == 0) ? 1 : (c.unit == 1) ? 1024 : 1048576);
         if (scaled > 64'sh7FFF_FFFF || scaled < -64'sh7FFF_FFFF) valid = 0;
         if (c.action == ACT_ADD && scaled < 0) valid = 0;
      end
      if (!valid) return o;
      if (c.action == ACT_ADD) begin
         freei = -1;
         ext = 0;
         for (i = 0; i < SLOTS; i++)
            if (!tbl_used[i]) begin
               if (freei < 0) freei = i;
            end else if (tbl_ext[i]) ext = 1;
         if (lookup_name(c.key) >= 0) o.status = ST_DUP;
         else if (freei < 0 || (c.ptype && ext)) o.status = ST_NOSLOT;
         else begin
            // walk gaps in address order from the header
            seen = '0;
            x = cfg_hdr;
            have = 0;
            found = 0;
            metric = 0;
            for (int k = 0; k <= SLOTS; k++) begin
               longint gs;
               i = (k < SLOTS) ? nearest_from(x, seen, -1) : -1;
               gs = x;
               if (i >= 0) begin
                  seen[i] = 1;
                  gl = tbl_start[i] - x;
                  x = tbl_start[i] + tbl_size[i];
               end else gl = disk_limit() - x;
               if (gl > scaled) begin
                  if (cfg_fit == FIT_FIRST) begin
                     if (!have) found = gs;
                     have = 1;
                  end else if (cfg_fit == FIT_WORST) begin
                     if (!have || gl > metric) begin
                        metric = gl;
                        found = gs;
                     end
                     have = 1;
                  end else begin
                     if (!have || gl - scaled < metric) begin
                        metric = gl - scaled;
                        found = gs;
                     end
                     have = 1;
                  end
               end
               if (i < 0) break;
            end
            if (!have) o.status = ST_NOSPACE;
            else begin
               tbl_used[freei] = 1;
               tbl_start[freei] = found;
               tbl_size[freei] = scaled;
               tbl_ext[freei] = c.ptype;
               tbl_name[freei] = c.key;
               o = '{ST_OK, freei[1:0], found[30:0], scaled[30:0]};
            end
         end
      end else if (c.action == ACT_DEL) begin
         i = lookup_name(c.key);
         if (i < 0) o.status = ST_NOTFOUND;
         else begin
            o = '{ST_OK, i[1:0], tbl_start[i][30:0], 31'd0};
            tbl_used[i] = 0;
            tbl_ext[i] = 0;
            tbl_size[i] = 0;
         end
      end else begin
         i = lookup_name(c.key);
         if (i < 0) o.status = ST_NOTFOUND;
         else begin
            sz = tbl_size[i];
            cend = tbl_start[i] + sz;
            if (scaled < 0 && scaled + sz < 0) o.status = ST_SHRINK;
            else begin
               if (scaled >= 0) begin
                  j = nearest_from(cend, '0, i);
                  space = (j < 0) ? disk_limit() - cend : tbl_start[j] - cend;
               end else space = 0;
               if (scaled >= 0 && space < scaled) o.status = ST_GROW;
               else begin
                  tbl_size[i] = sz + scaled;
                  o = '{ST_OK, i[1:0], tbl_start[i][30:0], tbl_size[i][30:0]};
               end
            end
         end
      end
      return o;
   endfunction

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) expected_outcomes.push_back(apply_command(cur_cmd));
         if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
               cmd_t c;
               c = pending_cmds.pop_front();
               cur_cmd <= c;
               start <= 1;
               req_action <= c.action;
               req_name_key <= c.key;
               req_amount <= c.amount;
               req_unit <= c.unit;
               req_part_type <= c.ptype;
               req_part_fit <= c.pfit;
            end else start <= 0;
         end
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("error %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unrequested result", 1, 0);
         end else begin
            outcome_t e;
            e = expected_outcomes.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_slot !== e.slot) report_mismatch("slot", rsp_slot, e.slot);
            if (rsp_part_start !== e.pstart)
               report_mismatch("part_start", rsp_part_start, e.pstart);
            if (rsp_part_size !== e.psize)
               report_mismatch("part_size", rsp_part_size, e.psize);
         end
      end
   end

   // watchdog: cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
         $display("partition_table_allocator_core: mismatch");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, longint value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value[31:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DISK) cfg_disk = value & 64'h7FFF_FFFF;
      else if (idx == CSR_HDR) cfg_hdr = value & 64'hFFF;
      else cfg_fit = value & 3;
   endtask

   task automatic configure(longint disk, longint hdr, int fit);
      csr_write(CSR_DISK, disk);
      csr_write(CSR_HDR, hdr);
      csr_write(CSR_FIT, fit);
      csr_valid <= 0;
   endtask

   // drain: every queued command sent and answered, then latency margin
   task automatic drain();
      wait (pending_cmds.size() == 0 && !start && expected_outcomes.size() == 0);
      repeat (SLOTS + 16) @(posedge clock);
   endtask

   function automatic cmd_t mk(logic [1:0] a, logic [31:0] k, longint amt, logic [1:0] u,
                               logic t = 0, logic [1:0] f = 0);
      cmd_t c;
      c = '{a, k, amt[31:0], u, t, f};
      return c;
   endfunction

   function automatic cmd_t random_cmd();
      cmd_t c;
      logic [31:0] names[6] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A,
                                32'h8000_0001, 32'h0000_0042};
      longint lim, v;
      int r;
      r = $urandom_range(99);
      c.action = (r < 45) ? ACT_ADD : (r < 70) ? ACT_DEL : (r < 97) ? ACT_RSZ : 2'd3;
      c.key = ($urandom_range(9) == 0) ? $urandom : names[$urandom_range(5)];
      c.unit = ($urandom_range(49) == 0) ? 2'd3 : $urandom_range(2);
      c.ptype = ($urandom_range(3) == 0);
      c.pfit = $urandom_range(2);
      lim = cfg_disk / 3;
      if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
      if (c.unit == 1) lim = lim / 1024;
      else if (c.unit == 2) lim = lim / 1048576;
      if (lim > 32'h7FFF_FFFF) lim = 32'h7FFF_FFFF;
      if ($urandom_range(19) == 0) c.amount = $urandom;
      else begin
         v = longint'($urandom) % (lim + 1);
         if (c.action == ACT_RSZ) begin
            v = v / 2;
            if ($urandom_range(1)) v = -v;
         end
         c.amount = v[31:0];
      end
      return c;
   endfunction

   task automatic run_random(int n, int pct);
      idle_pct = pct;
      repeat (n) pending_cmds.push_back(random_cmd());
      drain();
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_action = 0;
      req_name_key = 0;
      req_amount = 0;
      req_unit = 0;
      req_part_type = 0;
      req_part_fit = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: small disk, first fit
      configure(10000, 156, FIT_FIRST);
      pending_cmds.push_back(mk(ACT_ADD, 32'h0, 1000, 0, 0, 2));
      pending_cmds.push_back(mk(ACT_ADD, 32'h0, 10, 0));                 // duplicate
      pending_cmds.push_back(mk(ACT_ADD, 32'hFFFF_FFFF, 2, 1, 1, 1));    // extended
      pending_cmds.push_back(mk(ACT_ADD, 32'h7, 1, 0, 1));               // second extended
      pending_cmds.push_back(mk(ACT_ADD, 32'h8, 0, 0));                  // zero size
      pending_cmds.push_back(mk(ACT_ADD, 32'h9, 100000, 0));             // no space
      pending_cmds.push_back(mk(ACT_ADD, 32'h9, 500, 0));
      pending_cmds.push_back(mk(ACT_ADD, 32'hA, 5, 0));                  // table full
      pending_cmds.push_back(mk(ACT_DEL, 32'h5555, 0, 0));               // not found
      pending_cmds.push_back(mk(ACT_DEL, 32'h8, 0, 0));
      pending_cmds.push_back(mk(ACT_RSZ, 32'h0, 100, 0));                // grow blocked by next entry
      pending_cmds.push_back(mk(ACT_RSZ, 32'h9, 1000000, 0));            // grow fail
      pending_cmds.push_back(mk(ACT_RSZ, 32'h9, -501, 0));               // shrink fail
      pending_cmds.push_back(mk(ACT_RSZ, 32'h9, -500, 0));               // to zero
      pending_cmds.push_back(mk(ACT_RSZ, 32'h77, 1, 0));                 // not found
      pending_cmds.push_back(mk(ACT_ADD, 32'hB, -1, 0));                 // negative add
      pending_cmds.push_back(mk(ACT_ADD, 32'hB, 2048, 2));               // scale overflow
      pending_cmds.push_back(mk(ACT_RSZ, 32'h0, 32'h8000_0000, 0));      // most negative
      pending_cmds.push_back(mk(2'd3, 32'h0, 1, 0));                     // bad action
      pending_cmds.push_back(mk(ACT_ADD, 32'hC, 1, 2'd3));               // bad unit
      pending_cmds.push_back(mk(ACT_ADD, 32'hB, 32'h7FFF_FFFF, 0));
      drain();

      configure(64'h7FFF_FFFF, 4095, FIT_WORST);
      run_random(180, 0);
      configure(20000, 0, 1);
      run_random(180, 69);
      configure(0, 156, FIT_FIRST);
      run_random(60, 0);
      configure(50000, 4095, 3);
      run_random(180, 38);
      configure(3000000, 100, FIT_FIRST);
      run_random(180, 69);
      configure(64'h7FFF_FFFF, 0, 1);
      run_random(180, 0);
      configure(5000, 156, FIT_WORST);
      run_random(190, 38);

      if (errors == 0) $display("partition_table_allocator_core: match");
      else $display("partition_table_allocator_core: mismatch");
      $finish;
   end
endmodule

@@ partition_table_allocator_core.f @@
+incdir+hw/rtl
hw/rtl/pta_pkg.sv
hw/rtl/pta_ctrl.sv
hw/rtl/pta_dp.sv
hw/rtl/partition_table_allocator_core.sv
tb/sv/tb_partition_table_allocator_core.sv
